// File: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, phase codes and helper functions for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int MAX_URI_BYTES      = 256;
    localparam int MAX_VERSION_DIGITS = 4;

    localparam int UriCntW = (MAX_URI_BYTES > 2) ? $clog2(MAX_URI_BYTES) : 1;
    localparam int DigCntW = $clog2(MAX_VERSION_DIGITS + 1);

    localparam logic [13:0] VERSION_CAP = 14'd9999;

    // Parse phases
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_METHOD      = 4'd1;
    localparam logic [3:0] PH_URI_WS      = 4'd2;
    localparam logic [3:0] PH_URI         = 4'd3;
    localparam logic [3:0] PH_VER_SEP     = 4'd4;
    localparam logic [3:0] PH_VER_KEY     = 4'd5;
    localparam logic [3:0] PH_MAJOR       = 4'd6;
    localparam logic [3:0] PH_MINOR_FIRST = 4'd7;
    localparam logic [3:0] PH_MINOR       = 4'd8;
    localparam logic [3:0] PH_LINE_WS     = 4'd9;
    localparam logic [3:0] PH_EXPECT_LF   = 4'd10;
    localparam logic [3:0] PH_HEADERS     = 4'd11;
    localparam logic [3:0] PH_DONE        = 4'd12;

    // Result kinds
    localparam logic KIND_URI     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam logic [31:0] WIN_BLANK_LINE = 32'h0D0A0D0A;
    localparam logic [31:0] WIN_HOST_MIXED = 32'h486F7374;
    localparam logic [31:0] WIN_HOST_LOWER = 32'h686F7374;
    localparam logic [31:0] WIN_HOST_UPPER = 32'h484F5354;

    typedef struct packed {
        logic [3:0]         phase;
        logic [2:0]         kidx;
        logic [UriCntW-1:0] uri_cnt;
        logic [DigCntW-1:0] dig_cnt;
        logic [13:0]        major;
        logic [13:0]        minor;
        logic [23:0]        recent;
    } parse_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  uri_byte;
        logic        bad;
        logic [13:0] major;
        logic [13:0] minor;
        logic [7:0]  uri_len;
    } result_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Letters of the method keyword
    function automatic logic [7:0] get_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Letters of the version keyword
    function automatic logic [7:0] http_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Append one decimal digit, saturating at the cap
    function automatic logic [13:0] add_digit(input logic [13:0] v, input logic [7:0] b);
        logic [16:0] n;
        logic [7:0]  d;
        d = b - CH_ZERO;
        n = ({3'b000, v} << 3) + ({3'b000, v} << 1) + {9'd0, d};
        return (n > {3'b000, VERSION_CAP}) ? VERSION_CAP : n[13:0];
    endfunction

endpackage

// File: rtl/core/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module hrlp_step (
    input  logic [7:0]            data_byte,
    input  logic                  begin_request,
    input  hrlp_pkg::parse_state_t cur_state,
    output hrlp_pkg::parse_state_t next_state,
    output logic                  res_valid,
    output hrlp_pkg::result_t     res
);

    hrlp_pkg::parse_state_t st;
    logic [31:0]            window;
    logic [31:0]            cnt_wide;
    logic                   go_uri;
    logic                   go_minor;
    logic                   go_ws;
    logic                   do_end;
    logic                   do_line_end;
    logic                   fin;
    logic                   fin_bad;
    logic                   emit_uri;

    always_comb begin
        // Start of a new request clears the parser
        st = cur_state;
        if (begin_request) begin
            st = '0;
            st.phase = hrlp_pkg::PH_METHOD;
        end

        next_state  = st;
        window      = {st.recent, data_byte};
        go_uri      = 1'b0;
        go_minor    = 1'b0;
        go_ws       = 1'b0;
        do_end      = 1'b0;
        do_line_end = 1'b0;
        fin         = 1'b0;
        fin_bad     = 1'b0;
        emit_uri    = 1'b0;

        if (st.phase != hrlp_pkg::PH_IDLE && st.phase != hrlp_pkg::PH_DONE) begin
            next_state.recent = window[23:0];

            // Per-phase handling; some phases continue into the next one
            unique case (st.phase)
                hrlp_pkg::PH_METHOD: begin
                    if (st.kidx == 3'd0 && hrlp_pkg::is_blank(data_byte)) begin
                        // skip leading blanks
                    end else if (st.kidx > 3'd2 ||
                                 data_byte != hrlp_pkg::get_char(st.kidx)) begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else if (st.kidx == 3'd2) begin
                        next_state.kidx  = 3'd0;
                        next_state.phase = hrlp_pkg::PH_URI_WS;
                    end else begin
                        next_state.kidx = st.kidx + 3'd1;
                    end
                end
                hrlp_pkg::PH_URI_WS: begin
                    if (!hrlp_pkg::is_blank(data_byte)) begin
                        go_uri = 1'b1;
                    end
                end
                hrlp_pkg::PH_URI: begin
                    go_uri = 1'b1;
                end
                hrlp_pkg::PH_VER_SEP: begin
                    if (hrlp_pkg::is_blank(data_byte)) begin
                        // skip blanks
                    end else if (data_byte == hrlp_pkg::CH_H) begin
                        next_state.kidx  = 3'd1;
                        next_state.phase = hrlp_pkg::PH_VER_KEY;
                    end else begin
                        do_end = 1'b1;
                    end
                end
                hrlp_pkg::PH_VER_KEY: begin
                    if (st.kidx > 3'd4 || data_byte != hrlp_pkg::http_char(st.kidx)) begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else if (st.kidx == 3'd4) begin
                        next_state.kidx  = 3'd0;
                        next_state.phase = hrlp_pkg::PH_MAJOR;
                    end else begin
                        next_state.kidx = st.kidx + 3'd1;
                    end
                end
                hrlp_pkg::PH_MAJOR: begin
                    if (data_byte == hrlp_pkg::CH_DOT) begin
                        if (st.dig_cnt == '0) begin
                            fin = 1'b1; fin_bad = 1'b1;
                        end else begin
                            next_state.phase = hrlp_pkg::PH_MINOR_FIRST;
                        end
                    end else if (!hrlp_pkg::is_digit(data_byte) ||
                                 st.dig_cnt >= hrlp_pkg::DigCntW'(hrlp_pkg::MAX_VERSION_DIGITS))
                    begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else begin
                        next_state.dig_cnt = st.dig_cnt + 1'b1;
                        next_state.major   = hrlp_pkg::add_digit(st.major, data_byte);
                    end
                end
                hrlp_pkg::PH_MINOR_FIRST: begin
                    if (!hrlp_pkg::is_digit(data_byte)) begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else begin
                        next_state.phase = hrlp_pkg::PH_MINOR;
                        go_minor = 1'b1;
                    end
                end
                hrlp_pkg::PH_MINOR: begin
                    go_minor = 1'b1;
                end
                hrlp_pkg::PH_LINE_WS: begin
                    go_ws = 1'b1;
                end
                hrlp_pkg::PH_EXPECT_LF: begin
                    if (data_byte == hrlp_pkg::CH_LF) begin
                        do_line_end = 1'b1;
                    end else begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end
                end
                hrlp_pkg::PH_HEADERS: begin
                    if (window == hrlp_pkg::WIN_BLANK_LINE) begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else if (window == hrlp_pkg::WIN_HOST_MIXED ||
                                 window == hrlp_pkg::WIN_HOST_LOWER ||
                                 window == hrlp_pkg::WIN_HOST_UPPER) begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    next_state.phase = hrlp_pkg::PH_DONE;
                end
            endcase

            // Copy URI bytes until a blank, line end, NUL or the length limit
            if (go_uri) begin
                next_state.phase = hrlp_pkg::PH_URI;
                if (hrlp_pkg::is_blank(data_byte)) begin
                    next_state.phase = hrlp_pkg::PH_VER_SEP;
                end else if (data_byte == hrlp_pkg::CH_CR || data_byte == hrlp_pkg::CH_LF) begin
                    do_end = 1'b1;
                end else if (data_byte == hrlp_pkg::CH_NUL) begin
                    fin = 1'b1; fin_bad = 1'b1;
                end else if ({1'b0, st.uri_cnt} + 1'b1 >=
                             (hrlp_pkg::UriCntW + 1)'(hrlp_pkg::MAX_URI_BYTES)) begin
                    fin = 1'b1; fin_bad = 1'b1;
                end else begin
                    next_state.uri_cnt = st.uri_cnt + 1'b1;
                    emit_uri = 1'b1;
                end
            end

            // Minor digits share the digit budget with the major
            if (go_minor) begin
                if (hrlp_pkg::is_digit(data_byte)) begin
                    if (st.dig_cnt >= hrlp_pkg::DigCntW'(hrlp_pkg::MAX_VERSION_DIGITS)) begin
                        fin = 1'b1; fin_bad = 1'b1;
                    end else begin
                        next_state.dig_cnt = st.dig_cnt + 1'b1;
                        next_state.minor   = hrlp_pkg::add_digit(st.minor, data_byte);
                    end
                end else begin
                    next_state.phase = hrlp_pkg::PH_LINE_WS;
                    go_ws = 1'b1;
                end
            end

            // Trailing blanks before the line end
            if (go_ws && !hrlp_pkg::is_blank(data_byte)) begin
                do_end = 1'b1;
            end

            // Line end: CR waits for LF, LF ends the line, anything else fails
            if (do_end) begin
                if (data_byte == hrlp_pkg::CH_CR) begin
                    next_state.phase = hrlp_pkg::PH_EXPECT_LF;
                end else if (data_byte == hrlp_pkg::CH_LF) begin
                    do_line_end = 1'b1;
                end else begin
                    fin = 1'b1; fin_bad = 1'b1;
                end
            end

            // Versions below 1.1 finish here, others go on to scan headers
            if (do_line_end) begin
                if (st.major == 14'd0 || (st.major == 14'd1 && st.minor == 14'd0)) begin
                    fin = 1'b1;
                end else begin
                    next_state.phase = hrlp_pkg::PH_HEADERS;
                end
            end

            if (fin) begin
                next_state.phase = hrlp_pkg::PH_DONE;
            end
        end
    end

    // Build the result item
    assign cnt_wide  = 32'(st.uri_cnt);
    assign res_valid = fin | emit_uri;

    always_comb begin
        res = '0;
        if (fin) begin
            res.kind    = hrlp_pkg::KIND_VERDICT;
            res.bad     = fin_bad;
            res.major   = fin_bad ? 14'd0 : st.major;
            res.minor   = fin_bad ? 14'd0 : st.minor;
            res.uri_len = cnt_wide[7:0];
        end else begin
            res.kind     = hrlp_pkg::KIND_URI;
            res.uri_byte = data_byte;
        end
    end

endmodule

// File: rtl/core/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// http_request_line_parser
// Checks a GET request line byte by byte, streams out the URI and one verdict.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_        in         tdata[7:0] data_byte, tuser[0] begin_request
//  m_        out        tdata[47:0] uri/verdict fields, tuser[0] result_kind
//
//  One byte is taken every cycle unless m_ stalls; a byte is captured in the
//  input register, then any result of its parse step goes into the result register.
//  The parse state update is one short combinational step per byte.
//  Reset clears the parse state to idle and empties both register stages.
//  A stall on m_ holds both stages; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module http_request_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] begin_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] uri_byte, [8] verdict_bad,
                                   // [22:9] version_major, [36:23] version_minor,
                                   // [44:37] uri_length, [47:45] zero
    output logic        m_tuser    // [0] result_kind
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_begin_reg;
    hrlp_pkg::parse_state_t state_reg;
    hrlp_pkg::parse_state_t state_next;
    logic                   out_valid_reg;
    hrlp_pkg::result_t      out_reg;
    logic                   step_valid;
    hrlp_pkg::result_t      step_res;
    logic                   advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_begin_reg <= s_tuser;
        end
    end

    hrlp_step u_step (
        .data_byte     (in_byte_reg),
        .begin_request (in_begin_reg),
        .cur_state     (state_reg),
        .next_state    (state_next),
        .res_valid     (step_valid),
        .res           (step_res)
    );

    // Advance the parse state and the result register together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // All-zero state is the idle phase with cleared counters
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && step_valid;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && step_valid) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'b000, out_reg.uri_len, out_reg.minor, out_reg.major,
                       out_reg.bad, out_reg.uri_byte};

endmodule
